[rtl/core/dhre_pkg.sv]
package dhre_pkg;

    localparam int REPORTS_DEF       = 8;
    localparam int DIALS             = 8;
    localparam int DIAL_EV_W         = 4;
    localparam int EVENTS_W          = DIALS * DIAL_EV_W;
    localparam int BTN_W             = 24;
    localparam int ID_W              = 4;
    localparam int PAGE_W            = 4;
    localparam int TICK_W            = 8;
    localparam int PTR_W             = 8;
    localparam logic [TICK_W-1:0] RELEASE_TICKS_RST = 8'd2;

    // Bit positions inside one dial's event nibble.
    localparam int EV_PRESS   = 0;
    localparam int EV_RELEASE = 1;
    localparam int EV_LEFT    = 2;
    localparam int EV_RIGHT   = 3;

    // Bit positions inside the page dial's event nibble.
    localparam int PG_HOME = 1;
    localparam int PG_PREV = 2;
    localparam int PG_NEXT = 3;

    typedef struct packed {
        logic [BTN_W-1:0] buttons;
        logic [BTN_W-1:0] awaiting;
        logic             changed;
    } t_entry;

endpackage

[rtl/core/dhre_store.sv]
module dhre_store
    import dhre_pkg::*;
#(
    parameter int REPORTS = REPORTS_DEF,
    parameter int IW      = $clog2(REPORTS_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [IW-1:0] i_addr,
    input  logic          i_we,
    input  t_entry        i_wdata,
    output t_entry        o_rdata
);

    logic [BTN_W-1:0] r_buttons  [REPORTS];
    logic [BTN_W-1:0] r_awaiting [REPORTS];
    logic [REPORTS-1:0] r_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REPORTS; i++) begin
                r_buttons[i]  <= '0;
                r_awaiting[i] <= '0;
            end
            r_changed <= '1;
        end else if (i_we) begin
            r_buttons[i_addr]  <= i_wdata.buttons;
            r_awaiting[i_addr] <= i_wdata.awaiting;
            r_changed[i_addr]  <= i_wdata.changed;
        end
    end

    assign o_rdata = {r_buttons[i_addr], r_awaiting[i_addr], r_changed[i_addr]};

endmodule

[rtl/core/dhre_dial_unit.sv]
module dhre_dial_unit
    import dhre_pkg::*;
(
    input  logic [EVENTS_W-1:0] i_events,
    input  t_entry              i_entry,
    output t_entry              o_entry,
    output logic                o_any_tap
);

    always_comb begin
        logic [DIAL_EV_W-1:0] ev;
        o_entry   = i_entry;
        o_any_tap = 1'b0;
        for (int i = 0; i < DIALS; i++) begin
            ev = i_events[DIAL_EV_W*i +: DIAL_EV_W];
            // A release in the same transaction as a press wins.
            if (ev[EV_PRESS]) begin
                o_entry.buttons[3*i] = 1'b1;
            end
            if (ev[EV_RELEASE]) begin
                o_entry.buttons[3*i] = 1'b0;
            end
            if (ev[EV_LEFT]) begin
                o_entry.buttons[3*i+1]  = 1'b1;
                o_entry.awaiting[3*i+1] = 1'b1;
            end
            if (ev[EV_RIGHT]) begin
                o_entry.buttons[3*i+2]  = 1'b1;
                o_entry.awaiting[3*i+2] = 1'b1;
            end
            if (ev != '0) begin
                o_entry.changed = 1'b1;
            end
            if (ev[EV_LEFT] || ev[EV_RIGHT]) begin
                o_any_tap = 1'b1;
            end
        end
    end

endmodule

[rtl/core/dial_event_hid_report_engine.sv]
// Dial event HID report engine. Each input transaction is one poll pass: it
// applies the dial events to the report of the selected page, steps the page,
// runs the release timer and then walks the report store one entry a clock
// cycle, releasing tapped buttons and picking the next changed report to send.
// A transaction runs from acceptance through the dial update (S_DIAL), the
// walk over the single-port report store (S_SWEEP) and the load of its result
// into the output register (S_DONE); the input is ready again in the following
// cycle. The result waits in the output register while the next transaction is
// being processed, and the load is held back only while the previous result
// has not been taken.
module dial_event_hid_report_engine
    import dhre_pkg::*;
#(
    parameter int REPORTS = REPORTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [TICK_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [EVENTS_W-1:0] i_dial_events,
    input  logic [3:0]          i_page_events,
    input  logic                i_timer_tick,
    input  logic                i_endpoint_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_send_valid,
    output logic [ID_W-1:0]     o_report_num,
    output logic [BTN_W-1:0]    o_button_bits,
    output logic [PAGE_W-1:0]   o_current_page
);

    localparam int IW = (REPORTS > 1) ? $clog2(REPORTS) : 1;
    localparam logic [IW-1:0]     LAST_IDX = IW'(REPORTS - 1);
    localparam logic [PAGE_W-1:0] MAX_PAGE = PAGE_W'(REPORTS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIAL  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [TICK_W-1:0]   r_release_ticks;
    logic [EVENTS_W-1:0] r_dials;
    logic [3:0]          r_page_ev;
    logic                r_tick;
    logic                r_ready;

    logic [PAGE_W-1:0] r_page, n_page;
    logic [TICK_W-1:0] r_count, n_count;
    logic              r_allowed, n_allowed;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [IW-1:0]     r_ptr_mod, n_ptr_mod;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_k, n_k;
    logic              r_found, n_found;
    logic [IW-1:0]     r_sel_idx, n_sel_idx;
    logic [BTN_W-1:0]  r_sel_bits, n_sel_bits;

    logic              r_out_valid, n_out_valid;
    logic              r_send, n_send;
    logic [ID_W-1:0]   r_id, n_id;
    logic [BTN_W-1:0]  r_bits, n_bits;
    logic [PAGE_W-1:0] r_cur_page, n_cur_page;

    logic [IW-1:0] st_addr;
    logic          st_we;
    t_entry        st_wdata;
    t_entry        st_rdata;
    t_entry        dial_entry;
    logic          dial_tap;

    dhre_store #(
        .REPORTS (REPORTS),
        .IW      (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (st_addr),
        .i_we    (st_we),
        .i_wdata (st_wdata),
        .o_rdata (st_rdata)
    );

    dhre_dial_unit u_dial (
        .i_events  (r_dials),
        .i_entry   (st_rdata),
        .o_entry   (dial_entry),
        .o_any_tap (dial_tap)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        logic              page_ok;
        logic [TICK_W-1:0] cnt;
        t_entry            ent;
        n_state     = r_state;
        n_page      = r_page;
        n_count     = r_count;
        n_allowed   = r_allowed;
        n_ptr       = r_ptr;
        n_ptr_mod   = r_ptr_mod;
        n_idx       = r_idx;
        n_k         = r_k;
        n_found     = r_found;
        n_sel_idx   = r_sel_idx;
        n_sel_bits  = r_sel_bits;
        n_out_valid = r_out_valid && !i_out_ready;
        n_send      = r_send;
        n_id        = r_id;
        n_bits      = r_bits;
        n_cur_page  = r_cur_page;
        st_addr     = r_idx;
        st_we       = 1'b0;
        st_wdata    = st_rdata;
        page_ok     = (r_page >= PAGE_W'(1)) && (r_page <= MAX_PAGE);
        cnt         = r_count;
        ent         = st_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIAL;
                end
            end
            S_DIAL: begin
                st_addr  = IW'(r_page - PAGE_W'(1));
                st_wdata = dial_entry;
                st_we    = page_ok;
                if (page_ok && dial_tap) begin
                    n_count   = '0;
                    n_allowed = 1'b0;
                end
                if (r_page_ev[PG_PREV]) begin
                    n_page = (n_page <= PAGE_W'(1) || n_page > MAX_PAGE) ?
                             MAX_PAGE : n_page - PAGE_W'(1);
                end
                if (r_page_ev[PG_NEXT]) begin
                    n_page = (n_page >= MAX_PAGE) ? PAGE_W'(1) : n_page + PAGE_W'(1);
                end
                if (r_page_ev[PG_HOME]) begin
                    n_page = PAGE_W'(1);
                end
                if (r_tick) begin
                    cnt = n_count + TICK_W'(1);
                    if (cnt >= r_release_ticks) begin
                        n_count   = '0;
                        n_allowed = 1'b1;
                    end else begin
                        n_count = cnt;
                    end
                end
                // The modulo copy of the pointer restarts whenever the
                // eight-bit pointer itself wraps.
                if (r_ready) begin
                    n_ptr     = r_ptr + PTR_W'(1);
                    n_ptr_mod = (r_ptr == '1 || r_ptr_mod == LAST_IDX) ?
                                '0 : r_ptr_mod + IW'(1);
                end
                n_idx   = n_ptr_mod;
                n_k     = '0;
                n_found = 1'b0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                st_addr = r_idx;
                if (r_allowed && !ent.changed && ent.awaiting != '0) begin
                    ent.buttons  = ent.buttons & ~ent.awaiting;
                    ent.awaiting = '0;
                    ent.changed  = 1'b1;
                end
                if (r_ready && !r_found && ent.changed) begin
                    ent.changed = 1'b0;
                    n_found     = 1'b1;
                    n_sel_idx   = r_idx;
                    n_sel_bits  = ent.buttons;
                end
                st_wdata = ent;
                st_we    = 1'b1;
                n_idx    = (r_idx == LAST_IDX) ? '0 : r_idx + IW'(1);
                n_k      = r_k + IW'(1);
                if (r_k == LAST_IDX) begin
                    n_k     = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_send      = r_found;
                    n_id        = r_found ? ID_W'(r_sel_idx) + ID_W'(1) : '0;
                    n_bits      = r_found ? r_sel_bits : '0;
                    n_cur_page  = r_page;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_release_ticks <= RELEASE_TICKS_RST;
            r_page          <= PAGE_W'(1);
            r_count         <= '0;
            r_allowed       <= 1'b0;
            r_ptr           <= '0;
            r_ptr_mod       <= '0;
            r_idx           <= '0;
            r_k             <= '0;
            r_found         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_page      <= n_page;
            r_count     <= n_count;
            r_allowed   <= n_allowed;
            r_ptr       <= n_ptr;
            r_ptr_mod   <= n_ptr_mod;
            r_idx       <= n_idx;
            r_k         <= n_k;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_release_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_dials   <= i_dial_events;
            r_page_ev <= i_page_events;
            r_tick    <= i_timer_tick;
            r_ready   <= i_endpoint_ready;
        end
        r_sel_idx  <= n_sel_idx;
        r_sel_bits <= n_sel_bits;
        r_send     <= n_send;
        r_id       <= n_id;
        r_bits     <= n_bits;
        r_cur_page <= n_cur_page;
    end

    assign o_out_valid    = r_out_valid;
    assign o_send_valid   = r_send;
    assign o_report_num   = r_id;
    assign o_button_bits  = r_bits;
    assign o_current_page = r_cur_page;

    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_page >= PAGE_W'(1)) && (r_page <= MAX_PAGE))
        else $error("selected page left its range");

    a_ptr_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr_mod <= LAST_IDX)
        else $error("rotate pointer modulo copy out of range");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_k == LAST_IDX) |=> (r_state == S_DONE))
        else $error("sweep did not end after the last report");

    a_send_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_send_valid) |->
        (o_report_num != '0) && (o_report_num <= ID_W'(REPORTS)))
        else $error("sent report carries a bad identifier");

    a_nosend_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_send_valid) |->
        (o_report_num == '0) && (o_button_bits == '0))
        else $error("idle result carries report data");

endmodule

[test/dial_event_hid_report_engine_test.sv]
`timescale 1ns / 100ps

module dial_event_hid_report_engine_test
    import dhre_pkg::*;
();

    localparam int N_REPORTS     = REPORTS_DEF;
    localparam int SETTLE_CYCLES = 2 * (N_REPORTS + 2) + 4;
    localparam int PHASES        = 4;

    typedef struct packed {
        logic              send;
        logic [ID_W-1:0]   id;
        logic [BTN_W-1:0]  bits;
        logic [PAGE_W-1:0] page;
    } t_report;

    typedef enum int {RX_STREAM, RX_THIRD, RX_COIN, RX_LONG} t_rx_mode;

    // Tracks the report store and page as the block should see them, and holds the
    // reports that are still to come out of the block.
    class t_report_scoreboard;
        logic [BTN_W-1:0]  buttons  [N_REPORTS];
        logic              changed  [N_REPORTS];
        logic [BTN_W-1:0]  awaiting [N_REPORTS];
        logic [PAGE_W-1:0] page;
        logic [TICK_W-1:0] rel_count;
        logic [TICK_W-1:0] rel_ticks;
        logic              rel_allowed;
        logic [PTR_W-1:0]  rot_ptr;
        t_report           due_reports [$];
        int                errors;
        int                passes;
        int                sends;
        int                releases;

        function new();
            for (int i = 0; i < N_REPORTS; i++) begin
                buttons[i]  = '0;
                changed[i]  = 1'b1;
                awaiting[i] = '0;
            end
            page        = 4'd1;
            rel_count   = '0;
            rel_ticks   = RELEASE_TICKS_RST;
            rel_allowed = 1'b0;
            rot_ptr     = '0;
            errors      = 0;
            passes      = 0;
            sends       = 0;
            releases    = 0;
        endfunction

        function void set_release_ticks(logic [TICK_W-1:0] v);
            rel_ticks = v;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        function void tap(int r, int b);
            buttons[r][b]  = 1'b1;
            awaiting[r][b] = 1'b1;
            changed[r]     = 1'b1;
            rel_count      = '0;
            rel_allowed    = 1'b0;
        endfunction

        function void note_pass(logic [EVENTS_W-1:0] dials, logic [3:0] page_ev,
                                logic tick, logic ready);
            logic [DIAL_EV_W-1:0] ev;
            t_report              res;
            int                   r;
            logic                 found;
            passes++;
            if (page >= 1 && page <= N_REPORTS) begin
                r = int'(page) - 1;
                for (int i = 0; i < DIALS; i++) begin
                    ev = dials[DIAL_EV_W*i +: DIAL_EV_W];
                    if (ev[EV_PRESS]) begin
                        buttons[r][3*i] = 1'b1;
                        changed[r]      = 1'b1;
                    end
                    if (ev[EV_RELEASE]) begin
                        buttons[r][3*i] = 1'b0;
                        changed[r]      = 1'b1;
                    end
                    if (ev[EV_LEFT])
                        tap(r, 3*i + 1);
                    if (ev[EV_RIGHT])
                        tap(r, 3*i + 2);
                end
            end
            if (page_ev[PG_PREV]) begin
                if (page <= 1 || page > N_REPORTS)
                    page = PAGE_W'(N_REPORTS);
                else
                    page = page - 1'b1;
            end
            if (page_ev[PG_NEXT]) begin
                if (page >= N_REPORTS)
                    page = 4'd1;
                else
                    page = page + 1'b1;
            end
            if (page_ev[PG_HOME])
                page = 4'd1;
            if (tick) begin
                rel_count = rel_count + 1'b1;
                if (rel_count >= rel_ticks) begin
                    rel_count   = '0;
                    rel_allowed = 1'b1;
                end
            end
            // Only reports that have already gone out may drop their tapped buttons.
            if (rel_allowed) begin
                for (int i = 0; i < N_REPORTS; i++) begin
                    if (!changed[i] && awaiting[i] != '0) begin
                        buttons[i]  = buttons[i] & ~awaiting[i];
                        awaiting[i] = '0;
                        changed[i]  = 1'b1;
                        releases++;
                    end
                end
            end
            res   = '0;
            found = 1'b0;
            if (ready) begin
                rot_ptr = rot_ptr + 1'b1;
                for (int k = 0; k < N_REPORTS; k++) begin
                    r = (int'(rot_ptr) + k) % N_REPORTS;
                    if (!found && changed[r]) begin
                        found      = 1'b1;
                        changed[r] = 1'b0;
                        res.send   = 1'b1;
                        res.id     = ID_W'(r + 1);
                        res.bits   = buttons[r];
                        sends++;
                    end
                end
            end
            res.page = page;
            due_reports.push_back(res);
        endfunction

        function void check_report(logic send, logic [ID_W-1:0] id,
                                   logic [BTN_W-1:0] bits, logic [PAGE_W-1:0] pg);
            t_report exp;
            if (due_reports.size() == 0) begin
                $display("%0t: report with none expected: send %0b id %0d bits %06h page %0d",
                         $time, send, id, bits, pg);
                errors++;
                return;
            end
            exp = due_reports.pop_front();
            if (send !== exp.send) begin
                $display("%0t: send_valid expected %0b actual %0b", $time, exp.send, send);
                errors++;
            end
            if (id !== exp.id) begin
                $display("%0t: report number expected %0d actual %0d", $time, exp.id, id);
                errors++;
            end
            if (bits !== exp.bits) begin
                $display("%0t: button_bits expected %06h actual %06h", $time, exp.bits, bits);
                errors++;
            end
            if (pg !== exp.page) begin
                $display("%0t: current_page expected %0d actual %0d", $time, exp.page, pg);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [TICK_W-1:0]   i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [EVENTS_W-1:0] i_dial_events = '0;
    logic [3:0]          i_page_events = '0;
    logic                i_timer_tick = 1'b0;
    logic                i_endpoint_ready = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_send_valid;
    logic [ID_W-1:0]     o_report_num;
    logic [BTN_W-1:0]    o_button_bits;
    logic [PAGE_W-1:0]   o_current_page;

    t_report_scoreboard sb;
    t_rx_mode           rx_mode = RX_STREAM;
    int                 rx_count = 0;
    int                 rx_hold = 0;
    int                 settings_used = 1;

    dial_event_hid_report_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_dial_events    (i_dial_events),
        .i_page_events    (i_page_events),
        .i_timer_tick     (i_timer_tick),
        .i_endpoint_ready (i_endpoint_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_send_valid     (o_send_valid),
        .o_report_num     (o_report_num),
        .o_button_bits    (o_button_bits),
        .o_current_page   (o_current_page)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches among four stall patterns, chosen at random.
    always @(negedge i_clk) begin
        if (rx_count % 80 == 0)
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        rx_count++;
        case (rx_mode)
            RX_STREAM: begin
                i_out_ready = 1'b1;
            end
            RX_THIRD: begin
                i_out_ready = (rx_count % 3 == 0);
            end
            RX_COIN: begin
                i_out_ready = 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_hold > 0) begin
                    i_out_ready = 1'b0;
                    rx_hold--;
                end else begin
                    i_out_ready = 1'b1;
                    rx_hold     = $urandom_range(0, 14);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_report(o_send_valid, o_report_num, o_button_bits, o_current_page);
    end

    task automatic send_pass(input logic [EVENTS_W-1:0] dials, input logic [3:0] page_ev,
                             input logic tick, input logic ready);
        @(negedge i_clk);
        i_in_valid       = 1'b1;
        i_dial_events    = dials;
        i_page_events    = page_ev;
        i_timer_tick     = tick;
        i_endpoint_ready = ready;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_pass(dials, page_ev, tick, ready);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_reports();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_release_ticks(input logic [TICK_W-1:0] v);
        drain_reports();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_release_ticks(v);
        settings_used++;
    endtask

    // Press and release bits appear with press_pct, turn bits with tap_pct, per dial.
    function automatic logic [EVENTS_W-1:0] make_dials(int tap_pct, int press_pct);
        logic [EVENTS_W-1:0] v;
        v = '0;
        for (int i = 0; i < DIALS; i++) begin
            if ($urandom_range(0, 99) < press_pct)
                v[DIAL_EV_W*i +: 2] = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < tap_pct)
                v[DIAL_EV_W*i + 2 +: 2] = 2'($urandom_range(0, 3));
        end
        return v;
    endfunction

    initial begin
        int                  phase_ticks [PHASES];
        int                  phase_items [PHASES];
        int                  phase_tap   [PHASES];
        int                  phase_tick  [PHASES];
        bit                  phase_gaps  [PHASES];
        logic [EVENTS_W-1:0] dials;
        logic [3:0]          page_ev;
        int                  n;
        int                  burst;

        phase_ticks = '{1, 255, 3, 0};
        phase_items = '{120, 265, 120, 120};
        phase_tap   = '{8, 0, 4, 2};
        phase_tick  = '{50, 100, 60, 70};
        phase_gaps  = '{1'b1, 1'b0, 1'b1, 1'b1};

        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed passes, run with the reset release delay.
        send_pass(32'h0000_0000, 4'h0, 1'b0, 1'b0);
        send_pass(32'h0000_0001, 4'h0, 1'b0, 1'b1);
        send_pass(32'h0000_0003, 4'h0, 1'b0, 1'b1);
        send_pass(32'h8000_0000, 4'h0, 1'b0, 1'b1);
        send_pass(32'h0000_0040, 4'h0, 1'b1, 1'b1);
        send_pass(32'h0000_0000, 4'h0, 1'b1, 1'b1);
        send_pass(32'h0000_0000, 4'h0, 1'b0, 1'b1);
        send_pass(32'h0000_0000, 4'h0, 1'b0, 1'b1);
        send_pass(32'h0000_0000, 4'h0, 1'b1, 1'b1);
        send_pass(32'hFFFF_FFFF, 4'h0, 1'b0, 1'b1);
        send_pass(32'h2222_2222, 4'h4, 1'b0, 1'b1);
        send_pass(32'h1111_1111, 4'h8, 1'b0, 1'b1);
        send_pass(32'h0000_0000, 4'h8, 1'b0, 1'b0);
        send_pass(32'h4444_4444, 4'h1, 1'b1, 1'b1);
        send_pass(32'h0000_0000, 4'h2, 1'b1, 1'b1);
        send_pass(32'h0000_0000, 4'hE, 1'b1, 1'b1);
        send_pass(32'h0000_0000, 4'hC, 1'b1, 1'b1);
        send_pass(32'h0000_0000, 4'h4, 1'b0, 1'b1);
        send_pass(32'h0000_0000, 4'h4, 1'b1, 1'b1);
        send_pass(32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1);
        repeat (5) send_pass(32'h0000_0000, 4'h0, 1'b1, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (phase_ticks[ph] == 0)
                write_release_ticks(TICK_W'($urandom_range(4, 60)));
            else
                write_release_ticks(TICK_W'(phase_ticks[ph]));
            n = 0;
            while (n < phase_items[ph]) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < phase_items[ph]; b++) begin
                    if (n == 0)
                        dials = make_dials(100, 50);
                    else if (phase_tap[ph] > 0 && $urandom_range(0, 99) < 5)
                        dials = $urandom;
                    else
                        dials = make_dials(phase_tap[ph], 10);
                    page_ev = ($urandom_range(0, 99) < 15) ? 4'($urandom_range(0, 15)) : 4'h0;
                    send_pass(dials, page_ev,
                              1'($urandom_range(0, 99) < phase_tick[ph]),
                              1'($urandom_range(0, 99) < 65));
                    n++;
                end
                if (phase_gaps[ph])
                    idle_gap($urandom_range(0, 8));
            end
        end

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d poll passes under %0d release delay settings.",
                 sb.passes, settings_used);
        $display("The block sent %0d reports and released tapped buttons %0d times.",
                 sb.sends, sb.releases);
        if (sb.errors == 0)
            $display("dial_event_hid_report_engine verification clean");
        else
            $display("dial_event_hid_report_engine verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d reports still due.", sb.pending());
        $display("dial_event_hid_report_engine verification failed");
        $finish;
    end

endmodule
